// ----- rtl/core/dsf_pkg.sv -----
// Shared widths, constants and types for the damped spring force block.
// Depends on nothing; every module of the block imports it.
package dsf_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int NUM_AXES   = 3;
    localparam int IN_W       = 32;
    localparam int CFG_W      = 31;
    localparam int IDX_W      = 2;
    localparam int S_DATA_W   = 4 * NUM_AXES * IN_W;
    localparam int M_DATA_W   = NUM_AXES * IN_W;
    localparam int M_USER_W   = 2;

    // separation and relative velocity
    localparam int DIFF_W     = IN_W + 1;
    localparam int SQ_W       = 2 * DIFF_W;
    localparam int SUM_W      = SQ_W;
    // square root
    localparam int ROOT_W     = SUM_W / 2;
    localparam int REM_W      = ROOT_W + 3;
    // unit direction
    localparam int Q_W        = FRAC_BITS + 1;
    localparam int U_W        = FRAC_BITS + 2;
    // dot product and scalar terms
    localparam int PROD_W     = DIFF_W + U_W;
    localparam int DOT_W      = PROD_W + 2;
    localparam int DOTS_W     = DOT_W - FRAC_BITS;
    localparam int BLO_W      = DOTS_W / 2;
    localparam int BHI_W      = DOTS_W - BLO_W;
    localparam int EXT_W      = ROOT_W + 1;
    localparam int AM_W       = CFG_W + ROOT_W;
    localparam int A_W        = AM_W - FRAC_BITS;
    localparam int BM_W       = CFG_W + DOTS_W;
    localparam int B_W        = BM_W - FRAC_BITS;
    localparam int S_W        = ((A_W > B_W) ? A_W : B_W) + 2;
    localparam int FP_W       = S_W + Q_W;
    localparam int FMS_W      = FP_W - FRAC_BITS;

    localparam logic [FMS_W-1:0] NEG_LIM = {{(FMS_W-IN_W){1'b0}}, 1'b1, {(IN_W-1){1'b0}}};
    localparam logic [FMS_W-1:0] POS_LIM = {{(FMS_W-IN_W+1){1'b0}}, {(IN_W-1){1'b1}}};
    localparam logic [IN_W-1:0]  NEG_MAX = {1'b1, {(IN_W-1){1'b0}}};
    localparam logic [IN_W-1:0]  POS_MAX = {1'b0, {(IN_W-1){1'b1}}};

    // queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int CNT_W      = FIFO_AW + 1;

    // register indexes
    localparam logic [IDX_W-1:0] CFG_STIFFNESS   = 2'd0;
    localparam logic [IDX_W-1:0] CFG_DAMPING     = 2'd1;
    localparam logic [IDX_W-1:0] CFG_REST_LENGTH = 2'd2;

    localparam logic [CFG_W-1:0] STIFFNESS_RST   = CFG_W'(65536);
    localparam logic [CFG_W-1:0] DAMPING_RST     = '0;
    localparam logic [CFG_W-1:0] REST_LENGTH_RST = CFG_W'(65536);

    typedef logic signed [DIFF_W-1:0] diff_t;

    typedef struct packed {
        logic [CFG_W-1:0] stiffness;
        logic [CFG_W-1:0] damping;
        logic [CFG_W-1:0] rest_length;
    } cfg_t;

    typedef struct packed {
        diff_t [NUM_AXES-1:0] d;
        diff_t [NUM_AXES-1:0] dv;
        logic  [SUM_W-1:0]    sumsq;
        logic                 coinc;
    } item_t;

    typedef struct packed {
        item_t              it;
        logic [REM_W-1:0]   rem;
        logic [ROOT_W-1:0]  root;
    } sqrt_t;

    typedef struct packed {
        diff_t [NUM_AXES-1:0]             dv;
        logic  [NUM_AXES-1:0]             neg;
        logic  [NUM_AXES-1:0]             m0;
        logic  [NUM_AXES-1:0][ROOT_W-1:0] rem;
        logic  [NUM_AXES-1:0][Q_W-1:0]    q;
        logic  [ROOT_W-1:0]               len;
        logic                             coinc;
    } div_t;

endpackage

// ----- rtl/core/damped_spring_force_top.sv -----
// Top level of the damped spring force block: configuration registers and the
// front end, queue and back end. Depends on dsf_pkg, dsf_front, dsf_queue, dsf_back.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+----------------------------------
//  s_       | in        | s_tvalid/s_tready  | 12 x 32-bit positions, velocities
//  m_       | out       | m_tvalid/m_tready  | 3 x 32-bit force, 2 flag bits
//  cfg_     | in        | cfg_we             | register index, 31-bit value
//
// One pair is taken per cycle while s_tready is high; a result passes through
// 3 front stages, the queue, 33 square root stages (one root bit each), 17
// division stages (one quotient bit each) and 8 scalar/force stages.
// Reset is synchronous on aresetn and clears only valid state and registers.
// A stall on m_ holds the back end; the four-entry queue then absorbs the
// front end before s_tready drops.
module damped_spring_force_top
    import dsf_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // first_pos_x, first_pos_y, first_pos_z, second_pos_x, second_pos_y,
    // second_pos_z, first_vel_x, first_vel_y, first_vel_z, second_vel_x,
    // second_vel_y, second_vel_z (32 bits each, lowest first)
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // force_x, force_y, force_z (32 bits each, lowest first)
    output logic [M_DATA_W-1:0] m_tdata,
    // coincident, saturated (lowest first)
    output logic [M_USER_W-1:0] m_tuser,
    input  logic                cfg_we,
    input  logic [IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]    cfg_wdata
);

    cfg_t  cfg_reg;
    logic  q_in_valid, q_in_ready, q_out_valid, q_out_ready;
    item_t q_in_item, q_out_item;

    // register writes; an index beyond the list is dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.stiffness   <= STIFFNESS_RST;
            cfg_reg.damping     <= DAMPING_RST;
            cfg_reg.rest_length <= REST_LENGTH_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_STIFFNESS:   cfg_reg.stiffness   <= cfg_wdata;
                CFG_DAMPING:     cfg_reg.damping     <= cfg_wdata;
                CFG_REST_LENGTH: cfg_reg.rest_length <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // front: subtract and square
    dsf_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .out_valid (q_in_valid),
        .out_ready (q_in_ready),
        .out_item  (q_in_item)
    );

    // queue: let front and back stall apart
    dsf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_in_valid),
        .in_ready  (q_in_ready),
        .in_item   (q_in_item),
        .out_valid (q_out_valid),
        .out_ready (q_out_ready),
        .out_item  (q_out_item)
    );

    // back: root, direction, scalar, force, clamp
    dsf_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .in_valid (q_out_valid),
        .in_ready (q_out_ready),
        .in_item  (q_out_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ----- rtl/core/dsf_front.sv -----
// Front end: takes pairs, forms separation, relative velocity and squared length.
// Depends on dsf_pkg.
module dsf_front
    import dsf_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                out_valid,
    input  logic                out_ready,
    output item_t               out_item
);

    logic  en;
    logic  f1_vld_reg, f2_vld_reg, f3_vld_reg;
    diff_t f1_d_reg  [NUM_AXES];
    diff_t f1_dv_reg [NUM_AXES];
    diff_t f1_d_next [NUM_AXES];
    diff_t f1_dv_next[NUM_AXES];
    diff_t f2_d_reg  [NUM_AXES];
    diff_t f2_dv_reg [NUM_AXES];
    logic [SQ_W-1:0] f2_sq_reg [NUM_AXES];
    logic [SQ_W-1:0] f2_sq_next[NUM_AXES];
    logic  f2_coinc_reg, f2_coinc_next;
    item_t f3_item_reg, f3_item_next;

    // stall the whole front only when its last stage cannot drain
    assign en       = !f3_vld_reg || out_ready;
    assign s_tready = en;

    always_comb begin
        for (int i = 0; i < NUM_AXES; i++) begin
            f1_d_next[i]  = $signed({s_tdata[(3+i)*IN_W+IN_W-1], s_tdata[(3+i)*IN_W +: IN_W]})
                          - $signed({s_tdata[i*IN_W+IN_W-1],     s_tdata[i*IN_W +: IN_W]});
            f1_dv_next[i] = $signed({s_tdata[(9+i)*IN_W+IN_W-1], s_tdata[(9+i)*IN_W +: IN_W]})
                          - $signed({s_tdata[(6+i)*IN_W+IN_W-1], s_tdata[(6+i)*IN_W +: IN_W]});
        end
    end

    always_comb begin
        f2_coinc_next = 1'b1;
        for (int i = 0; i < NUM_AXES; i++) begin
            f2_sq_next[i] = f1_d_reg[i] * f1_d_reg[i];
            if (f1_d_reg[i] != '0) begin
                f2_coinc_next = 1'b0;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_AXES; i++) begin
            f3_item_next.d[i]  = f2_d_reg[i];
            f3_item_next.dv[i] = f2_dv_reg[i];
        end
        f3_item_next.sumsq = f2_sq_reg[0] + f2_sq_reg[1] + f2_sq_reg[2];
        f3_item_next.coinc = f2_coinc_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_vld_reg <= 1'b0;
            f2_vld_reg <= 1'b0;
            f3_vld_reg <= 1'b0;
        end else if (en) begin
            f1_vld_reg <= s_tvalid;
            f2_vld_reg <= f1_vld_reg;
            f3_vld_reg <= f2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f1_d_reg     <= f1_d_next;
            f1_dv_reg    <= f1_dv_next;
            f2_d_reg     <= f1_d_reg;
            f2_dv_reg    <= f1_dv_reg;
            f2_sq_reg    <= f2_sq_next;
            f2_coinc_reg <= f2_coinc_next;
            f3_item_reg  <= f3_item_next;
        end
    end

    assign out_valid = f3_vld_reg;
    assign out_item  = f3_item_reg;

endmodule

// ----- rtl/core/dsf_queue.sv -----
// Short queue that decouples the front end from the back end.
// Depends on dsf_pkg.
module dsf_queue
    import dsf_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  out_valid,
    input  logic  out_ready,
    output item_t out_item
);

    item_t              mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               push, pop;

    assign in_ready  = (cnt_reg != CNT_W'(FIFO_DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_item  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(FIFO_DEPTH))
        else $error("queue count above depth");
    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (FIFO_AW'(wr_ptr_reg - rd_ptr_reg) == cnt_reg[FIFO_AW-1:0]))
        else $error("queue pointers disagree with count");
    a_push_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("queue count missed a push");
    a_pop_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !push) |=> (cnt_reg == $past(cnt_reg) - 1'b1))
        else $error("queue count missed a pop");
`endif

endmodule

// ----- rtl/core/dsf_back.sv -----
// Back end: square root, unit direction, spring and damping scalar, force and clamp.
// Depends on dsf_pkg.
module dsf_back
    import dsf_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  cfg_t                cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  item_t               in_item,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,
    output logic [M_USER_W-1:0] m_tuser
);

    logic en;
    logic out_vld_reg;

    assign en       = !out_vld_reg || m_tready;
    assign in_ready = en;

    // ---------------- square root, one root bit per stage ----------------
    sqrt_t             sq_src [ROOT_W];
    sqrt_t             sq_q   [ROOT_W];
    logic [ROOT_W-1:0] sq_vld_reg;

    always_comb begin
        sq_src[0].it   = in_item;
        sq_src[0].rem  = '0;
        sq_src[0].root = '0;
    end

    for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
        localparam int J = ROOT_W - 1 - k;
        sqrt_t            stage_reg, stage_next;
        logic [REM_W-1:0] t_rem, trial;

        if (k > 0) begin : g_link
            assign sq_src[k] = sq_q[k-1];
        end

        always_comb begin
            stage_next = sq_src[k];
            t_rem      = {sq_src[k].rem[REM_W-3:0], sq_src[k].it.sumsq[2*J+1 -: 2]};
            trial      = {1'b0, sq_src[k].root, 2'b01};
            if (t_rem >= trial) begin
                stage_next.rem  = t_rem - trial;
                stage_next.root = {sq_src[k].root[ROOT_W-2:0], 1'b1};
            end else begin
                stage_next.rem  = t_rem;
                stage_next.root = {sq_src[k].root[ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                stage_reg <= stage_next;
            end
        end

        assign sq_q[k] = stage_reg;
    end

    // ---------------- restoring division, one quotient bit per stage ----------------
    div_t           dv_src [Q_W];
    div_t           dv_q   [Q_W];
    logic [Q_W-1:0] dv_vld_reg;
    diff_t          d_abs;

    always_comb begin
        d_abs = '0;
        dv_src[0].len   = sq_q[ROOT_W-1].root;
        dv_src[0].coinc = sq_q[ROOT_W-1].it.coinc;
        for (int i = 0; i < NUM_AXES; i++) begin
            d_abs = sq_q[ROOT_W-1].it.d[i];
            if (sq_q[ROOT_W-1].it.d[i] < 0) begin
                d_abs = -sq_q[ROOT_W-1].it.d[i];
            end
            dv_src[0].dv[i]  = sq_q[ROOT_W-1].it.dv[i];
            dv_src[0].neg[i] = sq_q[ROOT_W-1].it.d[i] < 0;
            dv_src[0].m0[i]  = d_abs[0];
            dv_src[0].rem[i] = {{(ROOT_W-DIFF_W+1){1'b0}}, d_abs[DIFF_W-1:1]};
            dv_src[0].q[i]   = '0;
        end
    end

    for (genvar k = 0; k < Q_W; k++) begin : g_div
        localparam bit FIRST = (k == 0);
        div_t              stage_reg, stage_next;
        logic [ROOT_W:0]   t_num, t_dif;
        logic              ge;

        if (k > 0) begin : g_link
            assign dv_src[k] = dv_q[k-1];
        end

        always_comb begin
            stage_next = dv_src[k];
            t_num      = '0;
            t_dif      = '0;
            ge         = 1'b0;
            for (int i = 0; i < NUM_AXES; i++) begin
                t_num = {dv_src[k].rem[i], dv_src[k].m0[i] & FIRST};
                t_dif = t_num - {1'b0, dv_src[k].len};
                ge    = (t_num >= {1'b0, dv_src[k].len});
                stage_next.rem[i] = ge ? t_dif[ROOT_W-1:0] : t_num[ROOT_W-1:0];
                stage_next.q[i]   = {dv_src[k].q[i][Q_W-2:0], ge};
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                stage_reg <= stage_next;
            end
        end

        assign dv_q[k] = stage_reg;
    end

    // ---------------- scalar and force stages ----------------
    localparam int NP = 7;
    logic [NP-1:0] p_vld_reg;
    div_t          dl;

    logic signed [PROD_W-1:0] p1_prod_reg [NUM_AXES];
    logic signed [PROD_W-1:0] p1_prod_next[NUM_AXES];
    logic signed [EXT_W-1:0]  p1_ext_reg, p1_ext_next;
    logic signed [U_W-1:0]    u_v;

    logic signed [DOT_W-1:0]  p2_dot_reg, p2_dot_next;
    logic [AM_W-1:0]          p2_amul_reg, p2_amul_next;
    logic                     p2_extpos_reg;
    logic signed [EXT_W-1:0]  ext_abs;

    logic [CFG_W+BLO_W-1:0]   p3_blo_reg, p3_blo_next;
    logic [CFG_W+BHI_W-1:0]   p3_bhi_reg, p3_bhi_next;
    logic [A_W-1:0]           p3_a_reg;
    logic                     p3_extpos_reg, p3_dotpos_reg;
    logic signed [DOT_W-1:0]  dot_abs;
    logic [DOTS_W-1:0]        dmag;

    logic [B_W-1:0]           p4_b_reg;
    logic [A_W-1:0]           p4_a_reg;
    logic                     p4_extpos_reg, p4_dotpos_reg;
    logic [BM_W-1:0]          b_full;

    logic signed [S_W-1:0]    p5_s_reg, p5_s_next;
    logic signed [S_W-1:0]    sa, sb;

    logic [S_W-1:0]           p6_sm_reg;
    logic                     p6_sneg_reg;
    logic signed [S_W-1:0]    s_abs;

    logic [FMS_W-1:0]         p7_fm_reg   [NUM_AXES];
    logic [FMS_W-1:0]         p7_fm_next  [NUM_AXES];
    logic [NUM_AXES-1:0]      p7_fneg_reg;
    logic [FP_W-1:0]          fprod;

    // q, direction sign and coincidence ride along every scalar stage
    logic [NUM_AXES-1:0][Q_W-1:0] pq_reg   [NP];
    logic [NUM_AXES-1:0]          pneg_reg [NP];
    logic                         pco_reg  [NP];

    logic [IN_W-1:0]          out_f_reg  [NUM_AXES];
    logic [IN_W-1:0]          out_f_next [NUM_AXES];
    logic                     out_sat_reg, out_sat_next;
    logic                     out_co_reg;

    assign dl = dv_q[Q_W-1];

    always_comb begin
        u_v = '0;
        for (int i = 0; i < NUM_AXES; i++) begin
            u_v = $signed({1'b0, dl.q[i]});
            if (dl.neg[i]) begin
                u_v = -u_v;
            end
            p1_prod_next[i] = dl.dv[i] * u_v;
        end
        p1_ext_next = $signed({1'b0, dl.len})
                    - $signed({{(EXT_W-CFG_W){1'b0}}, cfg.rest_length});
    end

    always_comb begin
        p2_dot_next = DOT_W'(p1_prod_reg[0]) + DOT_W'(p1_prod_reg[1])
                    + DOT_W'(p1_prod_reg[2]);
        ext_abs = (p1_ext_reg < 0) ? -p1_ext_reg : p1_ext_reg;
        p2_amul_next = cfg.stiffness * ext_abs[ROOT_W-1:0];
    end

    always_comb begin
        dot_abs     = (p2_dot_reg < 0) ? -p2_dot_reg : p2_dot_reg;
        dmag        = dot_abs[DOT_W-1:FRAC_BITS];
        p3_blo_next = cfg.damping * dmag[BLO_W-1:0];
        p3_bhi_next = cfg.damping * dmag[DOTS_W-1:BLO_W];
    end

    always_comb begin
        b_full = {p3_bhi_reg, {BLO_W{1'b0}}} + BM_W'(p3_blo_reg);
    end

    always_comb begin
        sa = $signed({{(S_W-A_W){1'b0}}, p4_a_reg});
        sb = $signed({{(S_W-B_W){1'b0}}, p4_b_reg});
        if (p4_extpos_reg) begin
            sa = -sa;
        end
        if (p4_dotpos_reg) begin
            sb = -sb;
        end
        p5_s_next = sa + sb;
        s_abs     = (p5_s_reg < 0) ? -p5_s_reg : p5_s_reg;
    end

    always_comb begin
        fprod = '0;
        for (int i = 0; i < NUM_AXES; i++) begin
            fprod = p6_sm_reg * pq_reg[5][i];
            p7_fm_next[i] = fprod[FP_W-1:FRAC_BITS];
        end
    end

    // clamp each component to the signed 32-bit range
    always_comb begin
        out_sat_next = 1'b0;
        for (int i = 0; i < NUM_AXES; i++) begin
            if (p7_fneg_reg[i]) begin
                if (p7_fm_reg[i] > NEG_LIM) begin
                    out_f_next[i] = NEG_MAX;
                    out_sat_next  = 1'b1;
                end else begin
                    out_f_next[i] = -p7_fm_reg[i][IN_W-1:0];
                end
            end else begin
                if (p7_fm_reg[i] > POS_LIM) begin
                    out_f_next[i] = POS_MAX;
                    out_sat_next  = 1'b1;
                end else begin
                    out_f_next[i] = p7_fm_reg[i][IN_W-1:0];
                end
            end
            if (pco_reg[6]) begin
                out_f_next[i] = '0;
            end
        end
        if (pco_reg[6]) begin
            out_sat_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_vld_reg  <= '0;
            dv_vld_reg  <= '0;
            p_vld_reg   <= '0;
            out_vld_reg <= 1'b0;
        end else if (en) begin
            sq_vld_reg  <= {sq_vld_reg[ROOT_W-2:0], in_valid};
            dv_vld_reg  <= {dv_vld_reg[Q_W-2:0], sq_vld_reg[ROOT_W-1]};
            p_vld_reg   <= {p_vld_reg[NP-2:0], dv_vld_reg[Q_W-1]};
            out_vld_reg <= p_vld_reg[NP-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_prod_reg   <= p1_prod_next;
            p1_ext_reg    <= p1_ext_next;
            p2_dot_reg    <= p2_dot_next;
            p2_amul_reg   <= p2_amul_next;
            p2_extpos_reg <= (p1_ext_reg > 0);
            p3_blo_reg    <= p3_blo_next;
            p3_bhi_reg    <= p3_bhi_next;
            p3_a_reg      <= p2_amul_reg[AM_W-1:FRAC_BITS];
            p3_extpos_reg <= p2_extpos_reg;
            p3_dotpos_reg <= (p2_dot_reg > 0);
            p4_b_reg      <= b_full[BM_W-1:FRAC_BITS];
            p4_a_reg      <= p3_a_reg;
            p4_extpos_reg <= p3_extpos_reg;
            p4_dotpos_reg <= p3_dotpos_reg;
            p5_s_reg      <= p5_s_next;
            p6_sm_reg     <= s_abs;
            p6_sneg_reg   <= (p5_s_reg < 0);
            p7_fm_reg     <= p7_fm_next;
            p7_fneg_reg   <= pneg_reg[5] ^ {NUM_AXES{p6_sneg_reg}};
            pq_reg[0]     <= dl.q;
            pneg_reg[0]   <= dl.neg;
            pco_reg[0]    <= dl.coinc;
            for (int s = 1; s < NP; s++) begin
                pq_reg[s]   <= pq_reg[s-1];
                pneg_reg[s] <= pneg_reg[s-1];
                pco_reg[s]  <= pco_reg[s-1];
            end
            out_f_reg     <= out_f_next;
            out_sat_reg   <= out_sat_next;
            out_co_reg    <= pco_reg[6];
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {out_f_reg[2], out_f_reg[1], out_f_reg[0]};
    assign m_tuser  = {out_sat_reg, out_co_reg};

endmodule
